// ===== sv/tdtu_pkg.sv =====
`default_nettype none

package tdtu_pkg;

    localparam int TASK_COUNT  = 16;
    localparam int TIME_BITS   = 16;
    localparam int IDX_W       = $clog2(TASK_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input modes.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Task states.
    localparam logic [1:0] ST_READY    = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;

    // Operations queued from the front to the back.
    localparam logic [1:0] OP_EMPTY = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IDX_W-1:0]     addr_t;

    typedef struct packed {
        logic       used;
        logic [1:0] state;
        time_t      sleep;
        time_t      deadline;
        time_t      remaining;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] idx;
        entry_t     entry;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  task_id;
        logic        woken;
        logic [1:0]  state;
        logic [15:0] remaining;
        logic [15:0] sleep;
        logic        preempt;
        logic        last;
    } result_t;

    function automatic time_t time_from16(input logic [15:0] v);
        return TIME_BITS'(v);
    endfunction

    function automatic logic [15:0] time_to16(input time_t t);
        logic [31:0] w;
        w = 32'(t);
        return w[15:0];
    endfunction

    function automatic logic idx_in_range(input logic [3:0] idx);
        logic [31:0] w;
        w = {28'd0, idx};
        return w < 32'(TASK_COUNT);
    endfunction

endpackage

`default_nettype wire

// ===== sv/tdtu_front.sv =====
`default_nettype none

module tdtu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [3:0]         task_index,
    input  wire logic               current_valid,
    input  wire logic               entry_used,
    input  wire logic [1:0]         entry_state,
    input  wire logic [15:0]        entry_sleep,
    input  wire logic [15:0]        entry_deadline,
    input  wire logic [15:0]        entry_remaining,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_data,
    output logic                    cmd_valid,
    output tdtu_pkg::cmd_t          cmd,
    input  wire logic               cmd_pop
);

    logic                        kernel_running_reg;
    tdtu_pkg::cmd_t              q_reg [tdtu_pkg::QUEUE_DEPTH];
    logic [tdtu_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tdtu_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tdtu_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        push;
    logic                        in_range;
    tdtu_pkg::cmd_t              cls;

    assign in_range = tdtu_pkg::idx_in_range(task_index);

    // Classify the item; an ignored tick, an out-of-range index or an unknown mode becomes an empty op.
    always_comb
    begin
        cls.idx             = task_index;
        cls.entry.used      = entry_used;
        cls.entry.state     = entry_state;
        cls.entry.sleep     = tdtu_pkg::time_from16(entry_sleep);
        cls.entry.deadline  = tdtu_pkg::time_from16(entry_deadline);
        cls.entry.remaining = tdtu_pkg::time_from16(entry_remaining);
        case (mode)
            tdtu_pkg::MODE_TICK:
            begin
                if (kernel_running_reg && current_valid && in_range)
                    cls.op = tdtu_pkg::OP_TICK;
                else
                    cls.op = tdtu_pkg::OP_EMPTY;
            end
            tdtu_pkg::MODE_WRITE:
                cls.op = in_range ? tdtu_pkg::OP_WRITE : tdtu_pkg::OP_EMPTY;
            tdtu_pkg::MODE_READ:
                cls.op = in_range ? tdtu_pkg::OP_READ : tdtu_pkg::OP_EMPTY;
            default:
                cls.op = tdtu_pkg::OP_EMPTY;
        endcase
    end

    assign item_stall = (count_reg == (tdtu_pkg::QPTR_W + 1)'(tdtu_pkg::QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == tdtu_pkg::QPTR_W'(tdtu_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            if (rd_ptr_reg == tdtu_pkg::QPTR_W'(tdtu_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
            count_next = count_reg + 1'b1;
        else if (!push && cmd_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_running_reg <= 1'b0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
                kernel_running_reg <= cfg_data;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

// ===== sv/tdtu_back.sv =====
`default_nettype none

module tdtu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire tdtu_pkg::cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 res_valid,
    output tdtu_pkg::result_t    res,
    input  wire logic            res_stall
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_CURRD = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    localparam tdtu_pkg::addr_t LAST_ADDR = tdtu_pkg::IDX_W'(tdtu_pkg::TASK_COUNT - 1);

    // Task table: one write and one registered read per cycle.
    tdtu_pkg::entry_t                mem [tdtu_pkg::TASK_COUNT];
    logic [tdtu_pkg::TASK_COUNT-1:0] vld_reg;
    tdtu_pkg::entry_t                rd_data_reg;
    logic                            rd_vld_reg;
    tdtu_pkg::entry_t                rd_entry;

    logic                   mem_we, mem_re;
    tdtu_pkg::addr_t        mem_waddr, mem_raddr;
    tdtu_pkg::entry_t       mem_wdata;

    logic [2:0]             state_reg, state_next;
    tdtu_pkg::addr_t        walk_reg, walk_next;
    tdtu_pkg::addr_t        cur_reg, cur_next;
    logic [3:0]             cur_id_reg, cur_id_next;
    logic                   have_reg, have_next;
    tdtu_pkg::time_t        soonest_reg, soonest_next;
    logic                   preempt_reg, preempt_next;

    logic                   out_valid_reg;
    tdtu_pkg::result_t      out_reg;
    logic                   out_free;
    logic                   out_load;
    tdtu_pkg::result_t      out_next;

    tdtu_pkg::entry_t       upd;
    logic                   wake, expire, report;
    tdtu_pkg::entry_t       fin;
    logic                   wake_preempt;

    assign rd_entry  = rd_vld_reg ? rd_data_reg : '0;
    assign out_free  = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Tick update of the entry under the walk pointer.
    always_comb
    begin
        upd    = rd_entry;
        wake   = 1'b0;
        expire = 1'b0;
        if (rd_entry.used)
        begin
            if (rd_entry.state == tdtu_pkg::ST_SLEEPING)
            begin
                if (rd_entry.sleep != '0)
                    upd.sleep = rd_entry.sleep - 1'b1;
                if (upd.sleep == '0)
                begin
                    upd.state     = tdtu_pkg::ST_READY;
                    upd.remaining = rd_entry.deadline;
                    wake          = 1'b1;
                end
            end
            else if (rd_entry.state inside {tdtu_pkg::ST_READY, tdtu_pkg::ST_RUNNING})
            begin
                if (rd_entry.remaining != '0)
                    upd.remaining = rd_entry.remaining - 1'b1;
                if (upd.remaining == '0 && rd_entry.state == tdtu_pkg::ST_RUNNING)
                begin
                    upd.remaining = rd_entry.deadline;
                    if (walk_reg != '0)
                        upd.state = tdtu_pkg::ST_READY;
                    expire = 1'b1;
                end
            end
        end
        report = wake && (walk_reg != cur_reg);
    end

    // Final decision on the current task, read back after the walk.
    always_comb
    begin
        fin          = rd_entry;
        wake_preempt = have_reg && (cur_reg == '0 || soonest_reg < rd_entry.remaining);
        if (wake_preempt && rd_entry.state == tdtu_pkg::ST_RUNNING && cur_reg != '0)
            fin.state = tdtu_pkg::ST_READY;
    end

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        cur_next     = cur_reg;
        cur_id_next  = cur_id_reg;
        have_next    = have_reg;
        soonest_next = soonest_reg;
        preempt_next = preempt_reg;
        cmd_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = walk_reg;
        mem_wdata    = upd;
        mem_re       = 1'b0;
        mem_raddr    = walk_reg;
        out_load     = 1'b0;
        out_next     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        tdtu_pkg::OP_TICK:
                        begin
                            cmd_pop      = 1'b1;
                            mem_re       = 1'b1;
                            mem_raddr    = '0;
                            walk_next    = '0;
                            cur_next     = tdtu_pkg::IDX_W'(cmd.idx);
                            cur_id_next  = cmd.idx;
                            have_next    = 1'b0;
                            soonest_next = '0;
                            preempt_next = 1'b0;
                            state_next   = S_WALK;
                        end
                        tdtu_pkg::OP_READ:
                        begin
                            cmd_pop     = 1'b1;
                            mem_re      = 1'b1;
                            mem_raddr   = tdtu_pkg::IDX_W'(cmd.idx);
                            cur_id_next = cmd.idx;
                            state_next  = S_READ;
                        end
                        tdtu_pkg::OP_WRITE:
                        begin
                            if (out_free)
                            begin
                                cmd_pop          = 1'b1;
                                mem_we           = 1'b1;
                                mem_waddr        = tdtu_pkg::IDX_W'(cmd.idx);
                                mem_wdata        = cmd.entry;
                                out_load         = 1'b1;
                                out_next.task_id = cmd.idx;
                                out_next.last    = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop          = 1'b1;
                                out_load         = 1'b1;
                                out_next.task_id = cmd.idx;
                                out_next.last    = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_next.task_id   = cur_id_reg;
                    out_next.state     = rd_entry.state;
                    out_next.remaining = tdtu_pkg::time_to16(rd_entry.remaining);
                    out_next.sleep     = tdtu_pkg::time_to16(rd_entry.sleep);
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_WALK:
            begin
                // A woken task other than the current one holds the walk until the output register frees.
                if (!report || out_free)
                begin
                    mem_we    = rd_entry.used;
                    mem_waddr = walk_reg;
                    mem_wdata = upd;
                    if (report)
                    begin
                        out_load           = 1'b1;
                        out_next.task_id   = 4'(walk_reg);
                        out_next.woken     = 1'b1;
                        out_next.state     = upd.state;
                        out_next.remaining = tdtu_pkg::time_to16(upd.remaining);
                        out_next.sleep     = tdtu_pkg::time_to16(upd.sleep);
                        have_next          = 1'b1;
                        if (!have_reg || upd.remaining < soonest_reg)
                            soonest_next = upd.remaining;
                    end
                    if (expire)
                        preempt_next = 1'b1;
                    if (walk_reg == LAST_ADDR)
                        state_next = S_CURRD;
                    else
                    begin
                        walk_next = walk_reg + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = walk_reg + 1'b1;
                    end
                end
            end

            S_CURRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                state_next = S_FINAL;
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    if (fin.state != rd_entry.state)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_reg;
                        mem_wdata = fin;
                    end
                    out_load           = 1'b1;
                    out_next.task_id   = cur_id_reg;
                    out_next.state     = fin.state;
                    out_next.remaining = tdtu_pkg::time_to16(fin.remaining);
                    out_next.sleep     = tdtu_pkg::time_to16(fin.sleep);
                    out_next.preempt   = preempt_reg || wake_preempt;
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_reg      <= '0;
            cur_reg       <= '0;
            cur_id_reg    <= '0;
            have_reg      <= 1'b0;
            soonest_reg   <= '0;
            preempt_reg   <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            cur_reg     <= cur_next;
            cur_id_reg  <= cur_id_next;
            have_reg    <= have_next;
            soonest_reg <= soonest_next;
            preempt_reg <= preempt_next;
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            if (mem_re)
                rd_vld_reg <= vld_reg[mem_raddr];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
        if (out_load)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/task_deadline_tick_unit.sv =====
// Task deadline tick unit: a table of task entries walked once per tick.
// Input channel (item_valid / item_stall) carries a mode and its fields:
// a tick, an entry write or an entry read. Items go into a two-deep queue,
// so up to two may be taken while the table is busy.
// Output channel (result_valid / result_stall) gives one result for a
// write, a read or an ignored tick, and for a tick one result per woken
// task other than the current one, then a final result; last marks the
// final result of each item and preempt_request is only set there.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) sets
// kernel_running; it is always ready and should be written while idle.
// A write or empty item is registered in the queue, then in the output
// register; a read also passes the table's registered read. A tick walks
// the table one entry per cycle via its single read port, unless a stalled
// woken report holds it, and rereads the current task for the final decision.
// A stalled output holds its result and pauses the walk at the next woken
// task other than the current one; the queue then fills and item_stall rises.
// Reset clears kernel_running, the queue and every entry to free/zero.
`default_nettype none

module task_deadline_tick_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [3:0]  task_index,
    input  wire logic        current_valid,
    input  wire logic        entry_used,
    input  wire logic [1:0]  entry_state,
    input  wire logic [15:0] entry_sleep,
    input  wire logic [15:0] entry_deadline,
    input  wire logic [15:0] entry_remaining,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [3:0]       task_id,
    output logic             woken,
    output logic [1:0]       task_state,
    output logic [15:0]      task_remaining,
    output logic [15:0]      task_sleep,
    output logic             preempt_request,
    output logic             last
);

    logic                 cmd_valid;
    logic                 cmd_pop;
    tdtu_pkg::cmd_t       cmd;
    tdtu_pkg::result_t    res;

    assign cfg_ready = 1'b1;

    tdtu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .mode            (mode),
        .task_index      (task_index),
        .current_valid   (current_valid),
        .entry_used      (entry_used),
        .entry_state     (entry_state),
        .entry_sleep     (entry_sleep),
        .entry_deadline  (entry_deadline),
        .entry_remaining (entry_remaining),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    tdtu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (result_valid),
        .res       (res),
        .res_stall (result_stall)
    );

    assign task_id         = res.task_id;
    assign woken           = res.woken;
    assign task_state      = res.state;
    assign task_remaining  = res.remaining;
    assign task_sleep      = res.sleep;
    assign preempt_request = res.preempt;
    assign last            = res.last;

    // Preemption is only decided on the final result of a tick.
    a_preempt_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && preempt_request |-> last)
        else $error("preempt_request on a result that is not last");

    // A woken report never closes an item.
    a_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && woken |-> !last)
        else $error("woken result marked last");

    // A woken task has just been made ready with its sleep count spent.
    a_woken_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && woken |-> task_state == tdtu_pkg::ST_READY && task_sleep == 16'd0)
        else $error("woken task is not ready with zero sleep");

endmodule

`default_nettype wire
